/* sv/srng_pkg.sv */
// Package for the shuffled minimal-standard generator: microcode word types,
// the control store, step addresses and fixed arithmetic constants.
// No dependencies; used by srng_seq and shuffled_minimal_standard_rng_top.
package srng_pkg;

	localparam int unsigned PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam logic [31:0] MODULUS = 32'd2147483647;
	localparam logic [16:0] MULT = 17'd16807;
	localparam int unsigned WARMUP = 8;
	localparam logic REG_SEED = 1'b0;
	localparam logic OPER_LOAD = 1'b1;

	localparam pc_t PC_DISPATCH = 4'd0;
	localparam pc_t PC_CHECK = 4'd1;
	localparam pc_t PC_INIT_MUL = 4'd2;
	localparam pc_t PC_INIT_RED = 4'd3;
	localparam pc_t PC_SLOT_MUL = 4'd4;
	localparam pc_t PC_SLOT_EST = 4'd5;
	localparam pc_t PC_CHK_MUL = 4'd6;
	localparam pc_t PC_SLOT_FIX = 4'd7;
	localparam pc_t PC_GEN_MUL = 4'd8;
	localparam pc_t PC_GEN_RED = 4'd9;
	localparam pc_t PC_BND_MUL = 4'd10;
	localparam pc_t PC_OUT = 4'd11;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_DISPATCH = 3'd1,
		OP_CHECK = 3'd2,
		OP_INIT_RED = 3'd3,
		OP_SLOT_EST = 3'd4,
		OP_SLOT_FIX = 3'd5,
		OP_GEN_RED = 3'd6,
		OP_OUT = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		A_X = 2'd0,
		A_LAST = 2'd1,
		A_NDIV = 2'd2
	} asel_t;

	typedef enum logic [1:0] {
		B_MULT = 2'd0,
		B_RECIP = 2'd1,
		B_SLOT = 2'd2,
		B_BOUND = 2'd3
	} bsel_t;

	typedef enum logic [2:0] {
		C_NEVER = 3'd0,
		C_DRAW = 3'd1,
		C_HEALTHY = 3'd2,
		C_LOOP_MORE = 3'd3,
		C_OUT_FREE = 3'd4
	} cond_t;

	typedef struct packed {
		op_t op;
		asel_t a_sel;
		bsel_t b_sel;
		logic mul_en;
		cond_t cond;
		logic hold;
		pc_t target;
	} cw_t;

	typedef struct packed {
		logic draw;
		logic healthy;
		logic loop_more;
		logic out_free;
	} flags_t;

	function automatic cw_t rom_word(pc_t pc);
		cw_t cw;
		cw = '{op: OP_NONE, a_sel: A_X, b_sel: B_MULT, mul_en: 1'b0,
			cond: C_NEVER, hold: 1'b0, target: PC_DISPATCH};
		case (pc)
			PC_DISPATCH: begin
				cw.op = OP_DISPATCH;
				cw.cond = C_DRAW;
				cw.target = PC_CHECK;
				cw.hold = 1'b1;
			end
			PC_CHECK: begin
				cw.op = OP_CHECK;
				cw.cond = C_HEALTHY;
				cw.target = PC_SLOT_MUL;
			end
			PC_INIT_MUL: begin
				cw.mul_en = 1'b1;
			end
			PC_INIT_RED: begin
				cw.op = OP_INIT_RED;
				cw.cond = C_LOOP_MORE;
				cw.target = PC_INIT_MUL;
			end
			PC_SLOT_MUL: begin
				cw.a_sel = A_LAST;
				cw.b_sel = B_RECIP;
				cw.mul_en = 1'b1;
			end
			PC_SLOT_EST: begin
				cw.op = OP_SLOT_EST;
			end
			PC_CHK_MUL: begin
				cw.a_sel = A_NDIV;
				cw.b_sel = B_SLOT;
				cw.mul_en = 1'b1;
			end
			PC_SLOT_FIX: begin
				cw.op = OP_SLOT_FIX;
			end
			PC_GEN_MUL: begin
				cw.mul_en = 1'b1;
			end
			PC_GEN_RED: begin
				cw.op = OP_GEN_RED;
			end
			PC_BND_MUL: begin
				cw.a_sel = A_LAST;
				cw.b_sel = B_BOUND;
				cw.mul_en = 1'b1;
			end
			PC_OUT: begin
				cw.op = OP_OUT;
				cw.cond = C_OUT_FREE;
				cw.target = PC_DISPATCH;
				cw.hold = 1'b1;
			end
			default: begin
				cw.cond = C_NEVER;
				cw.hold = 1'b0;
				cw.target = PC_DISPATCH;
			end
		endcase
		return cw;
	endfunction

endpackage

/* sv/srng_seq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on srng_pkg for the control word, flags and step addresses.
module srng_seq (
	input  logic clk,
	input  logic arst_n,
	input  srng_pkg::flags_t flags,
	output srng_pkg::cw_t cw
);

	srng_pkg::pc_t pc_q;
	srng_pkg::pc_t pc_next;
	logic take;

	assign cw = srng_pkg::rom_word(pc_q);

	always_comb begin
		case (cw.cond)
			srng_pkg::C_NEVER: take = 1'b0;
			srng_pkg::C_DRAW: take = flags.draw;
			srng_pkg::C_HEALTHY: take = flags.healthy;
			srng_pkg::C_LOOP_MORE: take = flags.loop_more;
			srng_pkg::C_OUT_FREE: take = flags.out_free;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			pc_next = cw.target;
		end else if (cw.hold) begin
			pc_next = pc_q;
		end else begin
			pc_next = srng_pkg::pc_t'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= srng_pkg::PC_DISPATCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* sv/shuffled_minimal_standard_rng_top.sv */
// Top level of the shuffled minimal-standard generator: APB seed register,
// datapath with shared multiplier and shuffle table; uses srng_pkg, srng_seq.
//
// Usage:
//   Request channel (cmd_valid/cmd_stall, fields operation and bound): a load
//   copies the seed register into the generator state and yields no result;
//   a draw yields one result (sample, scaled) on result_valid/result_stall.
//   Seed register at byte address 0, written over APB; the user must write it
//   only while the block idles, as the block itself does not enforce this.
//   A load completes in the dispatch step. An accepted draw walks nine
//   microcode steps through one shared 32x17 multiplier; the last one waits
//   for a free output register before raising result_valid. No request is
//   taken until the sequencer is back at dispatch. A draw that reinitializes
//   adds TABLE_SIZE+8 generator steps, each a multiply and a reduce step.
// Reset:
//   State, last output and seed clear to zero, so the first draw reinitializes
//   and fills the whole table before any entry is read.
// Stall:
//   A finished result waits in the output register; the block takes one more
//   draw, then stalls requests and holds its result until the first is taken.
module shuffled_minimal_standard_rng_top #(
	parameter int unsigned TABLE_SIZE = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  logic operation,
	input  logic [16:0] bound,
	output logic result_valid,
	input  logic result_stall,
	output logic [30:0] sample,
	output logic [15:0] scaled,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
	localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 8);
	localparam logic [63:0] NDIV = 64'd1 + (64'd2147483646 / TABLE_SIZE);
	localparam logic [63:0] RECIP = (64'd1 << 39) / NDIV;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE + 7);
	localparam logic [9:0] SLOT_MAX_W = 10'(TABLE_SIZE - 1);
	localparam logic [SLOT_W:0] SLOT_MAX_N = (SLOT_W + 1)'(TABLE_SIZE - 1);

	srng_pkg::cw_t cw;
	srng_pkg::flags_t flags;

	logic [31:0] seed_q;
	logic [31:0] state_q;
	logic [30:0] last_q;
	logic [31:0] x_q;
	logic [48:0] prod_q;
	logic [16:0] bound_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [30:0] rd_q;
	logic [30:0] tbl_q [TABLE_SIZE];
	logic result_valid_q;
	logic [30:0] sample_q;
	logic [15:0] scaled_q;

	logic cmd_acc;
	logic cfg_wr;
	logic out_free;
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [31:0] fold_sum;
	logic [30:0] red;
	logic [31:0] bnd_sum;
	logic [18:0] bnd_q;
	logic [15:0] scaled_next;
	logic [9:0] q_est;
	logic [31:0] rem;
	logic [SLOT_W:0] slot_inc;
	logic [SLOT_W-1:0] fill_idx;
	logic mem_we;
	logic [SLOT_W-1:0] mem_waddr;

	srng_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.cw(cw)
	);

	assign cmd_stall = (cw.op != srng_pkg::OP_DISPATCH);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign out_free = !result_valid_q || !result_stall;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == srng_pkg::REG_SEED);
	assign prdata = (paddr[2] == srng_pkg::REG_SEED) ? seed_q : 32'd0;

	assign flags.draw = cmd_acc && (operation != srng_pkg::OPER_LOAD);
	assign flags.healthy = !state_q[31] && (state_q != 32'd0) && (last_q != 31'd0);
	assign flags.loop_more = (cnt_q != CNT_LAST);
	assign flags.out_free = out_free;

	always_comb begin
		case (cw.a_sel)
			srng_pkg::A_X: mul_a = x_q;
			srng_pkg::A_LAST: mul_a = {1'b0, last_q};
			srng_pkg::A_NDIV: mul_a = NDIV[31:0];
			default: mul_a = x_q;
		endcase
		case (cw.b_sel)
			srng_pkg::B_MULT: mul_b = srng_pkg::MULT;
			srng_pkg::B_RECIP: mul_b = RECIP[16:0];
			srng_pkg::B_SLOT: mul_b = 17'(slot_q);
			srng_pkg::B_BOUND: mul_b = bound_q;
			default: mul_b = srng_pkg::MULT;
		endcase
	end

	// 2^31 == 1 mod (2^31 - 1): fold the high part onto the low part
	assign fold_sum = 32'(prod_q[48:31]) + 32'(prod_q[30:0]);
	assign red = (fold_sum >= srng_pkg::MODULUS) ?
		31'(fold_sum - srng_pkg::MODULUS) : fold_sum[30:0];

	assign bnd_sum = fold_sum;
	assign bnd_q = 19'(prod_q[48:31]) + 19'(bnd_sum >= srng_pkg::MODULUS);
	assign scaled_next = (bnd_q > 19'd65535) ? 16'hFFFF : bnd_q[15:0];

	assign q_est = prod_q[48:39];
	assign rem = {1'b0, last_q} - prod_q[31:0];
	assign slot_inc = {1'b0, slot_q} + 1'b1;
	assign fill_idx = SLOT_W'(CNT_LAST - cnt_q);

	assign mem_we = ((cw.op == srng_pkg::OP_INIT_RED) && (cnt_q >= CNT_W'(srng_pkg::WARMUP)))
		|| (cw.op == srng_pkg::OP_GEN_RED);
	assign mem_waddr = (cw.op == srng_pkg::OP_INIT_RED) ? fill_idx : slot_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_q[mem_waddr] <= red;
		end
		rd_q <= tbl_q[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
			state_q <= 32'd0;
			last_q <= 31'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				seed_q <= pwdata;
			end
			if ((cw.op == srng_pkg::OP_OUT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (cw.op)
				srng_pkg::OP_DISPATCH: begin
					if (cmd_acc && (operation == srng_pkg::OPER_LOAD)) begin
						state_q <= seed_q;
					end
				end
				srng_pkg::OP_INIT_RED: begin
					if (cnt_q == CNT_LAST) begin
						last_q <= red;
					end
				end
				srng_pkg::OP_GEN_RED: begin
					state_q <= {1'b0, red};
					last_q <= rd_q;
				end
				default: begin
					state_q <= state_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cw.mul_en) begin
			prod_q <= 49'(mul_a) * 49'(mul_b);
		end
		case (cw.op)
			srng_pkg::OP_DISPATCH: begin
				if (cmd_acc) begin
					bound_q <= bound;
				end
			end
			srng_pkg::OP_CHECK: begin
				cnt_q <= '0;
				if (flags.healthy) begin
					x_q <= state_q;
				end else if (state_q[31]) begin
					x_q <= 32'(~state_q + 1'b1);
				end else begin
					x_q <= 32'd1;
				end
			end
			srng_pkg::OP_INIT_RED: begin
				x_q <= {1'b0, red};
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			srng_pkg::OP_SLOT_EST: begin
				slot_q <= (q_est > SLOT_MAX_W) ? SLOT_MAX_W[SLOT_W-1:0] : q_est[SLOT_W-1:0];
			end
			srng_pkg::OP_SLOT_FIX: begin
				if (rem >= NDIV[31:0]) begin
					slot_q <= (slot_inc > SLOT_MAX_N) ?
						SLOT_MAX_N[SLOT_W-1:0] : slot_inc[SLOT_W-1:0];
				end
			end
			srng_pkg::OP_GEN_RED: begin
				x_q <= {1'b0, red};
			end
			srng_pkg::OP_OUT: begin
				if (out_free) begin
					sample_q <= last_q;
					scaled_q <= scaled_next;
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign sample = sample_q;
	assign scaled = scaled_q;

endmodule
